[hdl/swodo_pkg.sv]
`timescale 1ns / 1ps

package swodo_pkg;

  // field widths
  localparam int unsigned AngW   = 17;
  localparam int unsigned DistW  = 18;
  localparam int unsigned PosW   = 32;
  localparam int unsigned TrigW  = 32;

  // module count is fixed by the port list; the mean divides by a power of two
  localparam int unsigned Modules     = 4;
  localparam int unsigned ModW        = $clog2(Modules);
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned AtanLen     = 24;
  localparam int unsigned StepW       = $clog2(AtanLen);

  // angle reduction: offset makes heading plus steering positive,
  // then five restoring steps against the quarter turn
  localparam int unsigned QuarterTurn = 11520;
  localparam int unsigned AngOffset   = 12 * QuarterTurn;
  localparam int unsigned RedW        = 19;
  localparam int unsigned ReduceSteps = 5;
  localparam int unsigned ZShift      = 15;

  localparam int unsigned ProdW     = DistW + TrigW;
  localparam int unsigned SumW      = ProdW + ModW;
  localparam int unsigned MeanShift = 30 + ModW;
  localparam int unsigned QuotW     = SumW - MeanShift;
  localparam int unsigned DeltaW    = QuotW + 1;

  typedef logic signed [AngW-1:0]   ang_t;
  typedef logic signed [DistW-1:0]  dist_t;
  typedef logic signed [PosW-1:0]   pos_t;
  typedef logic signed [TrigW-1:0]  trig_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic signed [DeltaW-1:0] delta_t;

  localparam trig_t CordicX0 = TrigW'(652032874);
  localparam logic signed [SumW:0] MeanHalf = (SumW+1)'(64'd1 << (MeanShift - 1));

  typedef enum logic [3:0] {
    OpNone,
    OpCapture,
    OpAngLoad,
    OpReduce,
    OpRotate,
    OpMulSin,
    OpMulCos,
    OpAddCos,
    OpMean,
    OpAccum,
    OpOutput
  } op_e;

  typedef enum logic [3:0] {
    StIdle,
    StAngle,
    StReduce,
    StRotate,
    StMulSin,
    StMulCos,
    StAddCos,
    StMean,
    StAccum,
    StFinish
  } state_e;

  typedef struct packed {
    op_e             op;
    logic [ModW-1:0]  mod_idx;
    logic [StepW-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic init;
  } status_t;

  // atan(2^-i) in units of 2^-22 degree
  function automatic trig_t atan_entry(logic [StepW-1:0] i);
    trig_t r;
    unique case (i)
      5'd0:    r = TrigW'(188743680);
      5'd1:    r = TrigW'(111421900);
      5'd2:    r = TrigW'(58872272);
      5'd3:    r = TrigW'(29884485);
      5'd4:    r = TrigW'(15000234);
      5'd5:    r = TrigW'(7507429);
      5'd6:    r = TrigW'(3754631);
      5'd7:    r = TrigW'(1877430);
      5'd8:    r = TrigW'(938729);
      5'd9:    r = TrigW'(469366);
      5'd10:   r = TrigW'(234683);
      5'd11:   r = TrigW'(117342);
      5'd12:   r = TrigW'(58671);
      5'd13:   r = TrigW'(29335);
      5'd14:   r = TrigW'(14668);
      5'd15:   r = TrigW'(7334);
      5'd16:   r = TrigW'(3667);
      5'd17:   r = TrigW'(1833);
      5'd18:   r = TrigW'(917);
      5'd19:   r = TrigW'(458);
      5'd20:   r = TrigW'(229);
      5'd21:   r = TrigW'(115);
      5'd22:   r = TrigW'(57);
      5'd23:   r = TrigW'(29);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[hdl/swodo_ctrl.sv]
`timescale 1ns / 1ps

module swodo_ctrl #(
  parameter int unsigned CordicSteps = swodo_pkg::CordicSteps
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  swodo_pkg::status_t  status_i,
  output swodo_pkg::cmd_t     cmd_o
);

  localparam logic [swodo_pkg::StepW-1:0] LastRot =
    swodo_pkg::StepW'(CordicSteps - 1);
  localparam logic [swodo_pkg::StepW-1:0] LastRed =
    swodo_pkg::StepW'(swodo_pkg::ReduceSteps - 1);
  localparam logic [swodo_pkg::ModW-1:0] LastMod =
    swodo_pkg::ModW'(swodo_pkg::Modules - 1);

  swodo_pkg::state_e state_q, state_d;
  logic [swodo_pkg::ModW-1:0]  mod_q, mod_d;
  logic [swodo_pkg::StepW-1:0] step_q, step_d;
  logic out_valid_q, out_valid_d;
  logic fin_fire;

  // result register is free or being emptied this cycle
  assign fin_fire = (state_q == swodo_pkg::StFinish) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    mod_d   = mod_q;
    step_d  = step_q;
    unique case (state_q)
      swodo_pkg::StIdle: begin
        mod_d = '0;
        if (in_valid_i) state_d = swodo_pkg::StAngle;
      end
      swodo_pkg::StAngle: begin
        step_d = LastRed;
        if (status_i.init) state_d = swodo_pkg::StFinish;
        else state_d = swodo_pkg::StReduce;
      end
      swodo_pkg::StReduce: begin
        if (step_q == '0) state_d = swodo_pkg::StRotate;
        else step_d = step_q - 1'b1;
      end
      swodo_pkg::StRotate: begin
        if (step_q == LastRot) begin
          step_d  = '0;
          state_d = swodo_pkg::StMulSin;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      swodo_pkg::StMulSin: state_d = swodo_pkg::StMulCos;
      swodo_pkg::StMulCos: state_d = swodo_pkg::StAddCos;
      swodo_pkg::StAddCos: begin
        mod_d = mod_q + 1'b1;
        if (mod_q == LastMod) state_d = swodo_pkg::StMean;
        else state_d = swodo_pkg::StAngle;
      end
      swodo_pkg::StMean:   state_d = swodo_pkg::StAccum;
      swodo_pkg::StAccum:  state_d = swodo_pkg::StFinish;
      swodo_pkg::StFinish: begin
        if (fin_fire) state_d = swodo_pkg::StIdle;
      end
      default: state_d = swodo_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o.op      = swodo_pkg::OpNone;
    cmd_o.mod_idx = mod_q;
    cmd_o.step    = step_q;
    unique case (state_q)
      swodo_pkg::StIdle:   if (in_valid_i) cmd_o.op = swodo_pkg::OpCapture;
      swodo_pkg::StAngle:  if (!status_i.init) cmd_o.op = swodo_pkg::OpAngLoad;
      swodo_pkg::StReduce: cmd_o.op = swodo_pkg::OpReduce;
      swodo_pkg::StRotate: cmd_o.op = swodo_pkg::OpRotate;
      swodo_pkg::StMulSin: cmd_o.op = swodo_pkg::OpMulSin;
      swodo_pkg::StMulCos: cmd_o.op = swodo_pkg::OpMulCos;
      swodo_pkg::StAddCos: cmd_o.op = swodo_pkg::OpAddCos;
      swodo_pkg::StMean:   cmd_o.op = swodo_pkg::OpMean;
      swodo_pkg::StAccum:  cmd_o.op = swodo_pkg::OpAccum;
      swodo_pkg::StFinish: if (fin_fire) cmd_o.op = swodo_pkg::OpOutput;
      default:             cmd_o.op = swodo_pkg::OpNone;
    endcase
  end

  assign out_valid_d = fin_fire | (out_valid_q & ~out_ready_i);
  assign in_ready_o  = (state_q == swodo_pkg::StIdle);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swodo_pkg::StIdle;
      mod_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mod_q       <= mod_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[hdl/swodo_dp.sv]
`timescale 1ns / 1ps

module swodo_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  swodo_pkg::cmd_t     cmd_i,
  output swodo_pkg::status_t  status_o,
  input  logic                in_init_i,
  input  swodo_pkg::ang_t     gyro_angle_i,
  input  swodo_pkg::ang_t     wheel_angle_i [swodo_pkg::Modules],
  input  swodo_pkg::dist_t    wheel_dist_i [swodo_pkg::Modules],
  output swodo_pkg::pos_t     position_x_o,
  output swodo_pkg::pos_t     position_y_o
);

  localparam int unsigned RedW   = swodo_pkg::RedW;
  localparam int unsigned TrigW  = swodo_pkg::TrigW;
  localparam int unsigned SumW   = swodo_pkg::SumW;
  localparam int unsigned PosW   = swodo_pkg::PosW;
  localparam int unsigned QuotW  = swodo_pkg::QuotW;

  // round to nearest, ties away from zero, of sum / (modules * 2^30)
  function automatic swodo_pkg::delta_t mean_round(swodo_pkg::sum_t s);
    logic signed [SumW:0] ext;
    logic signed [SumW:0] rnd;
    logic [QuotW-1:0]     qv;
    ext = (SumW+1)'(s);
    rnd = s[SumW-1] ? (swodo_pkg::MeanHalf - ext) : (ext + swodo_pkg::MeanHalf);
    qv  = rnd[SumW-1:swodo_pkg::MeanShift];
    return s[SumW-1] ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
  endfunction

  function automatic swodo_pkg::pos_t sat_add(swodo_pkg::pos_t a, swodo_pkg::delta_t d);
    logic signed [PosW:0] s;
    swodo_pkg::pos_t r;
    s = (PosW+1)'(a) + (PosW+1)'(d);
    if (s[PosW] != s[PosW-1]) r = s[PosW] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
    else r = s[PosW-1:0];
    return r;
  endfunction

  logic init_q, init_d;
  swodo_pkg::ang_t   gyro_q, gyro_d;
  swodo_pkg::ang_t   wang_q [swodo_pkg::Modules];
  swodo_pkg::ang_t   wang_d [swodo_pkg::Modules];
  swodo_pkg::dist_t  wdist_q [swodo_pkg::Modules];
  swodo_pkg::dist_t  wdist_d [swodo_pkg::Modules];
  logic [RedW-1:0]   v_q, v_d;
  logic [1:0]        quad_q, quad_d;
  swodo_pkg::trig_t  x_q, x_d, y_q, y_d, z_q, z_d;
  swodo_pkg::prod_t  prod_q, prod_d;
  swodo_pkg::sum_t   sx_q, sx_d, sy_q, sy_d;
  swodo_pkg::delta_t dx_q, dx_d, dy_q, dy_d;
  swodo_pkg::pos_t   acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  swodo_pkg::pos_t   pos_x_q, pos_x_d, pos_y_q, pos_y_d;

  logic signed [RedW:0] ang_ext;
  logic [RedW-1:0]      red_div, red_next;
  logic                 red_ge;
  swodo_pkg::trig_t     xs, ys, at, sn, cs, trig_sel;
  swodo_pkg::dist_t     dist_sel;
  swodo_pkg::prod_t     mul;

  // heading plus steering, shifted positive by a whole number of turns
  assign ang_ext = (RedW+1)'(gyro_q) + (RedW+1)'(wang_q[cmd_i.mod_idx])
                 + (RedW+1)'(swodo_pkg::AngOffset);

  // one restoring step against quarter turn << step
  assign red_div  = RedW'(swodo_pkg::QuarterTurn) << cmd_i.step;
  assign red_ge   = (v_q >= red_div);
  assign red_next = red_ge ? (v_q - red_div) : v_q;

  assign xs = x_q >>> cmd_i.step;
  assign ys = y_q >>> cmd_i.step;
  assign at = swodo_pkg::atan_entry(cmd_i.step);

  always_comb begin
    unique case (quad_q)
      2'd0: begin sn = y_q;  cs = x_q;  end
      2'd1: begin sn = x_q;  cs = -y_q; end
      2'd2: begin sn = -y_q; cs = -x_q; end
      2'd3: begin sn = -x_q; cs = y_q;  end
      default: begin sn = y_q; cs = x_q; end
    endcase
  end

  assign dist_sel = wdist_q[cmd_i.mod_idx];
  assign trig_sel = (cmd_i.op == swodo_pkg::OpMulCos) ? cs : sn;
  assign mul      = dist_sel * trig_sel;

  always_comb begin
    init_d  = init_q;
    gyro_d  = gyro_q;
    wang_d  = wang_q;
    wdist_d = wdist_q;
    v_d     = v_q;
    quad_d  = quad_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    prod_d  = prod_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    acc_x_d = acc_x_q;
    acc_y_d = acc_y_q;
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    unique case (cmd_i.op)
      swodo_pkg::OpCapture: begin
        init_d  = in_init_i;
        gyro_d  = gyro_angle_i;
        wang_d  = wheel_angle_i;
        wdist_d = wheel_dist_i;
        sx_d    = '0;
        sy_d    = '0;
      end
      swodo_pkg::OpAngLoad: begin
        v_d    = ang_ext[RedW-1:0];
        quad_d = '0;
        x_d    = swodo_pkg::CordicX0;
        y_d    = '0;
      end
      swodo_pkg::OpReduce: begin
        v_d = red_next;
        if (cmd_i.step == swodo_pkg::StepW'(1)) quad_d[1] = red_ge;
        if (cmd_i.step == '0) begin
          quad_d[0] = red_ge;
          // residual below a quarter turn becomes the rotation phase
          z_d = TrigW'({red_next, {swodo_pkg::ZShift{1'b0}}});
        end
      end
      swodo_pkg::OpRotate: begin
        if (!z_q[TrigW-1]) begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - at;
        end else begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + at;
        end
      end
      swodo_pkg::OpMulSin: prod_d = mul;
      swodo_pkg::OpMulCos: begin
        prod_d = mul;
        sx_d   = sx_q + SumW'(prod_q);
      end
      swodo_pkg::OpAddCos: sy_d = sy_q + SumW'(prod_q);
      swodo_pkg::OpMean: begin
        dx_d = mean_round(sx_q);
        dy_d = mean_round(sy_q);
      end
      swodo_pkg::OpAccum: begin
        acc_x_d = sat_add(acc_x_q, dx_q);
        acc_y_d = sat_add(acc_y_q, dy_q);
      end
      swodo_pkg::OpOutput: begin
        pos_x_d = acc_x_q;
        pos_y_d = acc_y_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    init_q  <= init_d;
    gyro_q  <= gyro_d;
    wang_q  <= wang_d;
    wdist_q <= wdist_d;
    v_q     <= v_d;
    quad_q  <= quad_d;
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    prod_q  <= prod_d;
    sx_q    <= sx_d;
    sy_q    <= sy_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    pos_x_q <= pos_x_d;
    pos_y_q <= pos_y_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_x_q <= '0;
      acc_y_q <= '0;
    end else begin
      acc_x_q <= acc_x_d;
      acc_y_q <= acc_y_d;
    end
  end

  assign status_o.init = init_q;
  assign position_x_o  = pos_x_q;
  assign position_y_o  = pos_y_q;

endmodule

[hdl/swerve_odometry_update.sv]
`timescale 1ns / 1ps
// channel | handshake                | payload
// --------+--------------------------+-----------------------------------------------
// input   | in_valid_i / in_ready_o  | in_init_i, gyro_angle_i, wheel_angle_0..3_i,
//         |                          | wheel_dist_0..3_i
// output  | out_valid_o / out_ready_i| position_x_o, position_y_o
//
// a moving item passes, per module, through a load, 5 angle reduction steps,
// CordicSteps rotations of the one shared cordic unit, 2 products on the one
// shared multiplier and an add of the last product; then come the mean, the
// accumulation and the final write. an item in init goes from the angle state
// straight to the final write; reset clears the accumulated position to zero
// the result waits in an output register while the next item is worked on; a
// stalled output holds the controller only at that item's final write

module swerve_odometry_update #(
  parameter int unsigned CordicSteps = swodo_pkg::CordicSteps
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             in_init_i,
  input  swodo_pkg::ang_t  gyro_angle_i,
  input  swodo_pkg::ang_t  wheel_angle_0_i,
  input  swodo_pkg::ang_t  wheel_angle_1_i,
  input  swodo_pkg::ang_t  wheel_angle_2_i,
  input  swodo_pkg::ang_t  wheel_angle_3_i,
  input  swodo_pkg::dist_t wheel_dist_0_i,
  input  swodo_pkg::dist_t wheel_dist_1_i,
  input  swodo_pkg::dist_t wheel_dist_2_i,
  input  swodo_pkg::dist_t wheel_dist_3_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output swodo_pkg::pos_t  position_x_o,
  output swodo_pkg::pos_t  position_y_o
);

  swodo_pkg::cmd_t    cmd;
  swodo_pkg::status_t status;
  swodo_pkg::ang_t    wheel_angle [swodo_pkg::Modules];
  swodo_pkg::dist_t   wheel_dist [swodo_pkg::Modules];

  assign wheel_angle[0] = wheel_angle_0_i;
  assign wheel_angle[1] = wheel_angle_1_i;
  assign wheel_angle[2] = wheel_angle_2_i;
  assign wheel_angle[3] = wheel_angle_3_i;
  assign wheel_dist[0]  = wheel_dist_0_i;
  assign wheel_dist[1]  = wheel_dist_1_i;
  assign wheel_dist[2]  = wheel_dist_2_i;
  assign wheel_dist[3]  = wheel_dist_3_i;

  swodo_ctrl #(
    .CordicSteps(CordicSteps)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  swodo_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_init_i    (in_init_i),
    .gyro_angle_i (gyro_angle_i),
    .wheel_angle_i(wheel_angle),
    .wheel_dist_i (wheel_dist),
    .position_x_o (position_x_o),
    .position_y_o (position_y_o)
  );

endmodule
